// ----- design/spe_pkg.sv -----
// shared types, constants and the edge-test step table for the sphere/face rejection block
package spe_pkg;

  localparam int COORD_WIDTH_DEF      = 24;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int RADIUS_W             = 23;
  localparam int CFG_IDX_W            = 2;
  localparam int OUT_TDATA_W          = 8;
  localparam int MUL_DIGIT_W          = 12;
  localparam int JOBQ_DEPTH           = 2;
  localparam int STEP_W               = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_CENTER_Z = 2'd2,
    CFG_RADIUS   = 2'd3
  } cfg_idx_t;

  // operand selects of the shared multiplier
  typedef enum logic [3:0] {
    SEL_EX  = 4'd0,
    SEL_EY  = 4'd1,
    SEL_EZ  = 4'd2,
    SEL_NX  = 4'd3,
    SEL_NY  = 4'd4,
    SEL_NZ  = 4'd5,
    SEL_WX  = 4'd6,
    SEL_WY  = 4'd7,
    SEL_WZ  = 4'd8,
    SEL_CX  = 4'd9,
    SEL_CY  = 4'd10,
    SEL_CZ  = 4'd11,
    SEL_D   = 4'd12,
    SEL_R   = 4'd13,
    SEL_R2  = 4'd14,
    SEL_NSQ = 4'd15
  } opnd_sel_t;

  typedef enum logic [2:0] {
    DST_CX  = 3'd0,
    DST_CY  = 3'd1,
    DST_CZ  = 3'd2,
    DST_D   = 3'd3,
    DST_D2  = 3'd4,
    DST_NSQ = 3'd5,
    DST_R2  = 3'd6,
    DST_RHS = 3'd7
  } dst_sel_t;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_ADD  = 2'd1,
    MODE_SUB  = 2'd2
  } acc_mode_t;

  typedef struct packed {
    opnd_sel_t a;
    opnd_sel_t b;
    dst_sel_t  dst;
    acc_mode_t mode;
  } step_t;

  typedef struct packed {
    logic start;   // first edge of a face: clear the reject flag
    logic report;  // closing edge: deliver the face result
  } job_flags_t;

  localparam logic [STEP_W-1:0] STEP_SQUARE_D = 4'd9;
  localparam logic [STEP_W-1:0] STEP_LAST     = 4'd14;

  // edge vector, face normal, center offset and flags, per job
  function automatic int job_width(input int cw, input int nw);
    return 6 * (cw + 1) + 3 * nw + $bits(job_flags_t);
  endfunction

  // cross product, dot product, then the squared-distance compare
  function automatic step_t step_decode(input logic [STEP_W-1:0] step);
    step_t s;
    case (step)
      4'd0:    s = '{SEL_EY, SEL_NZ, DST_CX, MODE_LOAD};
      4'd1:    s = '{SEL_EZ, SEL_NY, DST_CX, MODE_SUB};
      4'd2:    s = '{SEL_EZ, SEL_NX, DST_CY, MODE_LOAD};
      4'd3:    s = '{SEL_EX, SEL_NZ, DST_CY, MODE_SUB};
      4'd4:    s = '{SEL_EX, SEL_NY, DST_CZ, MODE_LOAD};
      4'd5:    s = '{SEL_EY, SEL_NX, DST_CZ, MODE_SUB};
      4'd6:    s = '{SEL_CX, SEL_WX, DST_D, MODE_LOAD};
      4'd7:    s = '{SEL_CY, SEL_WY, DST_D, MODE_ADD};
      4'd8:    s = '{SEL_CZ, SEL_WZ, DST_D, MODE_ADD};
      4'd9:    s = '{SEL_D, SEL_D, DST_D2, MODE_LOAD};
      4'd10:   s = '{SEL_CX, SEL_CX, DST_NSQ, MODE_LOAD};
      4'd11:   s = '{SEL_CY, SEL_CY, DST_NSQ, MODE_ADD};
      4'd12:   s = '{SEL_CZ, SEL_CZ, DST_NSQ, MODE_ADD};
      4'd13:   s = '{SEL_R, SEL_R, DST_R2, MODE_LOAD};
      4'd14:   s = '{SEL_R2, SEL_NSQ, DST_RHS, MODE_LOAD};
      default: s = '{SEL_EX, SEL_EX, DST_CX, MODE_LOAD};
    endcase
    return s;
  endfunction

endpackage

// ----- design/spe_front.sv -----
// vertex intake: tracks face start, first and previous vertex, emits edge jobs
module spe_front #(
  parameter int CW    = spe_pkg::COORD_WIDTH_DEF,
  parameter int NW    = spe_pkg::NORMAL_FRAC_BITS_DEF + 2,
  parameter int JOB_W = spe_pkg::job_width(spe_pkg::COORD_WIDTH_DEF,
                                           spe_pkg::NORMAL_FRAC_BITS_DEF + 2)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] vertex_x,
  input  logic signed [CW-1:0] vertex_y,
  input  logic signed [CW-1:0] vertex_z,
  input  logic signed [NW-1:0] normal_x,
  input  logic signed [NW-1:0] normal_y,
  input  logic signed [NW-1:0] normal_z,
  input  logic                 last_vertex,
  input  logic signed [CW-1:0] center_x,
  input  logic signed [CW-1:0] center_y,
  input  logic signed [CW-1:0] center_z,
  output logic                 push_valid,
  input  logic                 push_ready,
  output logic [JOB_W-1:0]     job
);
  import spe_pkg::*;

  localparam int EW = CW + 1;

  logic                 inside_r, fresh_r, need_edge_r, need_close_r;
  logic signed [CW-1:0] prev_x_r, prev_y_r, prev_z_r;
  logic signed [CW-1:0] first_x_r, first_y_r, first_z_r;
  logic signed [CW-1:0] ep_x_r, ep_y_r, ep_z_r;
  logic signed [CW-1:0] v_x_r, v_y_r, v_z_r;
  logic signed [CW-1:0] fp_x_r, fp_y_r, fp_z_r;
  logic signed [NW-1:0] n_x_r, n_y_r, n_z_r;
  logic                 accept, push;
  logic [CW-1:0]        jp_x, jp_y, jp_z, jq_x, jq_y, jq_z;
  logic [EW-1:0]        e_x, e_y, e_z, w_x, w_y, w_z;
  job_flags_t           flags;

  assign in_ready   = !(need_edge_r || need_close_r);
  assign accept     = in_valid && in_ready;
  assign push_valid = need_edge_r || need_close_r;
  assign push       = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r     <= 1'b0;
      fresh_r      <= 1'b0;
      need_edge_r  <= 1'b0;
      need_close_r <= 1'b0;
    end else if (accept) begin
      if (!inside_r) begin
        fresh_r <= 1'b1;
      end
      inside_r     <= !last_vertex;
      need_edge_r  <= inside_r;
      need_close_r <= last_vertex;
    end else if (push) begin
      fresh_r <= 1'b0;
      if (need_edge_r) begin
        need_edge_r <= 1'b0;
      end else begin
        need_close_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ep_x_r   <= prev_x_r;
      ep_y_r   <= prev_y_r;
      ep_z_r   <= prev_z_r;
      v_x_r    <= vertex_x;
      v_y_r    <= vertex_y;
      v_z_r    <= vertex_z;
      n_x_r    <= normal_x;
      n_y_r    <= normal_y;
      n_z_r    <= normal_z;
      prev_x_r <= vertex_x;
      prev_y_r <= vertex_y;
      prev_z_r <= vertex_z;
      if (inside_r) begin
        fp_x_r <= first_x_r;
        fp_y_r <= first_y_r;
        fp_z_r <= first_z_r;
      end else begin
        fp_x_r    <= vertex_x;
        fp_y_r    <= vertex_y;
        fp_z_r    <= vertex_z;
        first_x_r <= vertex_x;
        first_y_r <= vertex_y;
        first_z_r <= vertex_z;
      end
    end
  end

  // open edge (previous, current) first, then the closing edge (current, first)
  always_comb begin
    if (need_edge_r) begin
      jp_x = ep_x_r;  jp_y = ep_y_r;  jp_z = ep_z_r;
      jq_x = v_x_r;   jq_y = v_y_r;   jq_z = v_z_r;
    end else begin
      jp_x = v_x_r;   jp_y = v_y_r;   jp_z = v_z_r;
      jq_x = fp_x_r;  jq_y = fp_y_r;  jq_z = fp_z_r;
    end
    e_x = {jp_x[CW-1], jp_x} - {jq_x[CW-1], jq_x};
    e_y = {jp_y[CW-1], jp_y} - {jq_y[CW-1], jq_y};
    e_z = {jp_z[CW-1], jp_z} - {jq_z[CW-1], jq_z};
    w_x = {center_x[CW-1], center_x} - {jq_x[CW-1], jq_x};
    w_y = {center_y[CW-1], center_y} - {jq_y[CW-1], jq_y};
    w_z = {center_z[CW-1], center_z} - {jq_z[CW-1], jq_z};
    flags.start  = fresh_r;
    flags.report = !need_edge_r;
    job = {flags, w_z, w_y, w_x, n_z_r, n_y_r, n_x_r, e_z, e_y, e_x};
  end

endmodule

// ----- design/spe_jobq.sv -----
// short job queue between the vertex front end and the edge-test back end
module spe_jobq #(
  parameter int W     = 8,
  parameter int DEPTH = spe_pkg::JOBQ_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);
  import spe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (rd_en) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !empty)
    else $error("job queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("job queue count out of range");

endmodule

// ----- design/spe_mul.sv -----
// shared sign-magnitude multiplier, one digit of the second operand per cycle
module spe_mul #(
  parameter int OPW = 86
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [OPW:0]      a,
  input  logic [OPW:0]      b,
  output logic              done,
  output logic [2*OPW-1:0]  mag,
  output logic              neg
);
  import spe_pkg::*;

  localparam int DIGW  = MUL_DIGIT_W;
  localparam int NDIG  = (OPW + DIGW - 1) / DIGW;
  localparam int BPW   = NDIG * DIGW;
  localparam int PW    = 2 * OPW;
  localparam int CNT_W = $clog2(NDIG + 1);

  logic [OPW-1:0]      mag_a_r;
  logic [BPW-1:0]      b_r;
  logic [PW-1:0]       acc_r;
  logic                neg_r, done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [OPW:0]        a_abs, b_abs;
  logic [OPW+DIGW-1:0] prod;
  logic [PW-1:0]       acc_nxt;

  assign a_abs   = a[OPW] ? (~a + 1'b1) : a;
  assign b_abs   = b[OPW] ? (~b + 1'b1) : b;
  assign prod    = mag_a_r * b_r[BPW-1 -: DIGW];
  assign acc_nxt = (acc_r << DIGW) + PW'(prod);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(NDIG);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // most significant digit first: shift the partial sum, add the next row
  always_ff @(posedge clk) begin
    if (start) begin
      mag_a_r <= a_abs[OPW-1:0];
      b_r     <= BPW'(b_abs[OPW-1:0]);
      acc_r   <= '0;
      neg_r   <= a[OPW] ^ b[OPW];
    end else if (cnt_r != '0) begin
      acc_r <= acc_nxt;
      b_r   <= b_r << DIGW;
    end
  end

  assign done = done_r;
  assign mag  = acc_r;
  assign neg  = neg_r;

endmodule

// ----- design/spe_back.sv -----
// edge-test sequencer: runs one job at a time through the shared multiplier
module spe_back #(
  parameter int CW    = spe_pkg::COORD_WIDTH_DEF,
  parameter int NW    = spe_pkg::NORMAL_FRAC_BITS_DEF + 2,
  parameter int JOB_W = spe_pkg::job_width(spe_pkg::COORD_WIDTH_DEF,
                                           spe_pkg::NORMAL_FRAC_BITS_DEF + 2)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  output logic                         job_pop,
  input  logic [JOB_W-1:0]             job,
  input  logic [spe_pkg::RADIUS_W-1:0] radius,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         may_touch
);
  import spe_pkg::*;

  localparam int EW    = CW + 1;
  localparam int WW    = CW + 1;
  localparam int CRW   = EW + NW + 1;
  localparam int DW    = CRW + WW + 2;
  localparam int NSQW  = 2 * CRW + 2;
  localparam int R2W   = 2 * RADIUS_W;
  localparam int OPW   = (NSQW > R2W) ? NSQW : R2W;
  localparam int PW    = 2 * OPW;
  localparam int FLG_W = $bits(job_flags_t);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ISSUE  = 4'b0010,
    S_WAIT   = 4'b0100,
    S_FINISH = 4'b1000
  } back_state_t;

  back_state_t       state_r;
  logic [STEP_W-1:0] step_r;
  logic              rejected_r, out_valid_r, may_touch_r;
  logic              start_r, report_r, hit_r;
  logic [EW-1:0]     ex_r, ey_r, ez_r;
  logic [NW-1:0]     nx_r, ny_r, nz_r;
  logic [WW-1:0]     wx_r, wy_r, wz_r;
  logic [CRW-1:0]    cx_r, cy_r, cz_r;
  logic [DW-1:0]     d_r;
  logic [PW-1:0]     d2_r;
  logic [NSQW-1:0]   nsq_r;
  logic [R2W-1:0]    r2_r;

  job_flags_t        job_flags;
  step_t             stp;
  logic [OPW:0]      opa, opb;
  logic [PW:0]       base, addend, sum;
  logic              mul_start, mul_done, mul_neg, sub, d_pos, rej_new, out_blocked;
  logic              report_fire;
  logic [PW-1:0]     mul_mag;

  function automatic logic [OPW:0] pick(input opnd_sel_t s);
    logic [OPW:0] v;
    case (s)
      SEL_EX:  v = {{(OPW+1-EW){ex_r[EW-1]}}, ex_r};
      SEL_EY:  v = {{(OPW+1-EW){ey_r[EW-1]}}, ey_r};
      SEL_EZ:  v = {{(OPW+1-EW){ez_r[EW-1]}}, ez_r};
      SEL_NX:  v = {{(OPW+1-NW){nx_r[NW-1]}}, nx_r};
      SEL_NY:  v = {{(OPW+1-NW){ny_r[NW-1]}}, ny_r};
      SEL_NZ:  v = {{(OPW+1-NW){nz_r[NW-1]}}, nz_r};
      SEL_WX:  v = {{(OPW+1-WW){wx_r[WW-1]}}, wx_r};
      SEL_WY:  v = {{(OPW+1-WW){wy_r[WW-1]}}, wy_r};
      SEL_WZ:  v = {{(OPW+1-WW){wz_r[WW-1]}}, wz_r};
      SEL_CX:  v = {{(OPW+1-CRW){cx_r[CRW-1]}}, cx_r};
      SEL_CY:  v = {{(OPW+1-CRW){cy_r[CRW-1]}}, cy_r};
      SEL_CZ:  v = {{(OPW+1-CRW){cz_r[CRW-1]}}, cz_r};
      SEL_D:   v = {{(OPW+1-DW){d_r[DW-1]}}, d_r};
      SEL_R:   v = {{(OPW+1-RADIUS_W){1'b0}}, radius};
      SEL_R2:  v = {{(OPW+1-R2W){1'b0}}, r2_r};
      SEL_NSQ: v = {{(OPW+1-NSQW){1'b0}}, nsq_r};
      default: v = '0;
    endcase
    return v;
  endfunction

  assign job_flags   = job[JOB_W-1 -: FLG_W];
  assign stp         = step_decode(step_r);
  assign d_pos       = !d_r[DW-1] && (d_r != '0);
  assign job_pop     = (state_r == S_IDLE) && job_valid;
  assign mul_start   = (state_r == S_ISSUE) && !((step_r == STEP_SQUARE_D) && !d_pos);
  assign rej_new     = (start_r ? 1'b0 : rejected_r) | hit_r;
  assign out_blocked = report_r && out_valid_r && !out_ready;
  assign report_fire = (state_r == S_FINISH) && report_r && !out_blocked;

  // operand muxes follow the operand registers as well as the step
  always_comb begin
    opa = pick(stp.a);
    opb = pick(stp.b);
  end

  // accumulate into the destination: one add or subtract per writeback
  always_comb begin
    case (stp.dst)
      DST_CX:  base = {{(PW+1-CRW){cx_r[CRW-1]}}, cx_r};
      DST_CY:  base = {{(PW+1-CRW){cy_r[CRW-1]}}, cy_r};
      DST_CZ:  base = {{(PW+1-CRW){cz_r[CRW-1]}}, cz_r};
      DST_D:   base = {{(PW+1-DW){d_r[DW-1]}}, d_r};
      DST_NSQ: base = {{(PW+1-NSQW){1'b0}}, nsq_r};
      default: base = '0;
    endcase
    if (stp.mode == MODE_LOAD) begin
      base = '0;
    end
    sub    = (stp.mode == MODE_SUB) ^ mul_neg;
    addend = {1'b0, mul_mag};
    sum    = sub ? (base - addend) : (base + addend);
  end

  spe_mul #(.OPW(OPW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (opa),
    .b     (opb),
    .done  (mul_done),
    .mag   (mul_mag),
    .neg   (mul_neg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      rejected_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a new face result may replace the one taken in the same cycle
      if (report_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            step_r  <= '0;
            state_r <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          // non-positive distance can never reject: skip the squares
          if ((step_r == STEP_SQUARE_D) && !d_pos) begin
            state_r <= S_FINISH;
          end else begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (mul_done) begin
            if (step_r == STEP_LAST) begin
              state_r <= S_FINISH;
            end else begin
              step_r  <= step_r + 1'b1;
              state_r <= S_ISSUE;
            end
          end
        end
        S_FINISH: begin
          if (!out_blocked) begin
            rejected_r <= rej_new;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      ex_r     <= job[0 +: EW];
      ey_r     <= job[EW +: EW];
      ez_r     <= job[2*EW +: EW];
      nx_r     <= job[3*EW +: NW];
      ny_r     <= job[3*EW+NW +: NW];
      nz_r     <= job[3*EW+2*NW +: NW];
      wx_r     <= job[3*EW+3*NW +: WW];
      wy_r     <= job[3*EW+3*NW+WW +: WW];
      wz_r     <= job[3*EW+3*NW+2*WW +: WW];
      start_r  <= job_flags.start;
      report_r <= job_flags.report;
      hit_r    <= 1'b0;
    end
    if ((state_r == S_WAIT) && mul_done) begin
      case (stp.dst)
        DST_CX:  cx_r  <= sum[CRW-1:0];
        DST_CY:  cy_r  <= sum[CRW-1:0];
        DST_CZ:  cz_r  <= sum[CRW-1:0];
        DST_D:   d_r   <= sum[DW-1:0];
        DST_D2:  d2_r  <= sum[PW-1:0];
        DST_NSQ: nsq_r <= sum[NSQW-1:0];
        DST_R2:  r2_r  <= sum[R2W-1:0];
        DST_RHS: hit_r <= (d2_r > mul_mag);
        default: hit_r <= hit_r;
      endcase
    end
    if (report_fire) begin
      may_touch_r <= !rej_new;
    end
  end

  assign out_valid = out_valid_r;
  assign may_touch = may_touch_r;

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_WAIT))
    else $error("multiplier result arrived outside the wait state");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (step_r <= STEP_LAST))
    else $error("edge-test step counter past the last step");

  a_report_lands: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FINISH) && report_r && !out_blocked) |=> out_valid_r)
    else $error("face result not presented after closing edge");

endmodule

// ----- design/sphere_polygon_edge_rejection.sv -----
// top level of the sphere versus convex face edge-plane rejection block
// multiplier: the second operand is taken in NDIG = ceil(OPW / 12) digits (8 by default)
// work per face: one edge test per vertex after the first of a face, plus the closing edge on
//   the last; an edge takes 15 multiplies, 9 when the distance is not positive
// reset: rst_n is synchronous, active low; clears control, queue and config (center, radius = 0)
module sphere_polygon_edge_rejection #(
  parameter int  COORD_WIDTH      = spe_pkg::COORD_WIDTH_DEF,
  parameter int  NORMAL_FRAC_BITS = spe_pkg::NORMAL_FRAC_BITS_DEF,
  localparam int NORMAL_W         = NORMAL_FRAC_BITS + 2,
  localparam int IN_FIELDS_W      = 3 * COORD_WIDTH + 3 * NORMAL_W,
  localparam int IN_TDATA_W       = ((IN_FIELDS_W + 7) / 8) * 8,
  localparam int CFG_DATA_W       = (COORD_WIDTH > spe_pkg::RADIUS_W) ? COORD_WIDTH
                                                                      : spe_pkg::RADIUS_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // vertex stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z, zero fill
  input  logic [IN_TDATA_W-1:0]           in_tdata,
  input  logic                            in_tlast,   // last_vertex
  // face results
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // may_touch, zero fill
  output logic [spe_pkg::OUT_TDATA_W-1:0] out_tdata,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [spe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]           cfg_data
);
  import spe_pkg::*;

  localparam int JOB_W = job_width(COORD_WIDTH, NORMAL_W);

  // sphere held in configuration
  logic [COORD_WIDTH-1:0] center_x_r, center_y_r, center_z_r;
  logic [RADIUS_W-1:0]    radius_r;

  // front to queue to back
  logic             push_valid, q_full, q_empty, q_pop;
  logic [JOB_W-1:0] push_job, pop_job;
  logic             may_touch;

  // config port is always able to take a transaction
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
      radius_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CENTER_X: center_x_r <= cfg_data[COORD_WIDTH-1:0];
        CFG_CENTER_Y: center_y_r <= cfg_data[COORD_WIDTH-1:0];
        CFG_CENTER_Z: center_z_r <= cfg_data[COORD_WIDTH-1:0];
        CFG_RADIUS:   radius_r   <= cfg_data[RADIUS_W-1:0];
        default:      radius_r   <= radius_r;
      endcase
    end
  end

  // front: registers each vertex, keeps first/previous vertex, forms the edge
  // vector and the center offset, and queues one job per edge to test
  spe_front #(
    .CW    (COORD_WIDTH),
    .NW    (NORMAL_W),
    .JOB_W (JOB_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .vertex_x    (in_tdata[0 +: COORD_WIDTH]),
    .vertex_y    (in_tdata[COORD_WIDTH +: COORD_WIDTH]),
    .vertex_z    (in_tdata[2*COORD_WIDTH +: COORD_WIDTH]),
    .normal_x    (in_tdata[3*COORD_WIDTH +: NORMAL_W]),
    .normal_y    (in_tdata[3*COORD_WIDTH+NORMAL_W +: NORMAL_W]),
    .normal_z    (in_tdata[3*COORD_WIDTH+2*NORMAL_W +: NORMAL_W]),
    .last_vertex (in_tlast),
    .center_x    (center_x_r),
    .center_y    (center_y_r),
    .center_z    (center_z_r),
    .push_valid  (push_valid),
    .push_ready  (!q_full),
    .job         (push_job)
  );

  // short queue lets the front keep taking vertices while an edge is in test
  spe_jobq #(
    .W     (JOB_W),
    .DEPTH (JOBQ_DEPTH)
  ) u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push_valid && !q_full),
    .wr_data (push_job),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (pop_job),
    .empty   (q_empty)
  );

  // back: cross product, signed distance, and the exact squared compare,
  // sequenced over one iterative multiplier; the output register holds the
  // face result until taken while the next edge is already in work
  spe_back #(
    .CW    (COORD_WIDTH),
    .NW    (NORMAL_W),
    .JOB_W (JOB_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!q_empty),
    .job_pop   (q_pop),
    .job       (pop_job),
    .radius    (radius_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .may_touch (may_touch)
  );

  assign out_tdata = {{(OUT_TDATA_W-1){1'b0}}, may_touch};

endmodule
